FILE: design/sorted_array_insert_and_read_core_macros.svh
// assertion macros shared by the sorted insertion array
`ifndef SORTED_ARRAY_INSERT_AND_READ_CORE_MACROS_SVH
`define SORTED_ARRAY_INSERT_AND_READ_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define SAI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked from one edge to the next outside reset
`define SAI_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: design/sai_pkg.sv
// types and constants of the sorted insertion array
`default_nettype none
package sai_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int OCC_W    = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } sai_status_t;

  // what one cell hands to its right-hand neighbour
  typedef struct packed {
    logic                     take;
    logic                     valid;
    logic signed [DATA_W-1:0] value;
  } sai_link_t;

  // insert command broadcast to every cell
  typedef struct packed {
    logic                     ins_en;
    logic signed [DATA_W-1:0] value;
  } sai_ins_t;

endpackage
`default_nettype wire

FILE: design/sai_ifs.sv
// handshake channels of the sorted insertion array
`default_nettype none
interface sai_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [sai_pkg::DATA_W-1:0] value;
  logic [sai_pkg::POS_W-1:0]        position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface sai_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sai_pkg::DATA_W-1:0] read_value;
  logic [1:0]                       status;
  logic [sai_pkg::OCC_W-1:0]        occupancy;

  modport source (output valid, output read_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input read_value, input status, input occupancy,
                  output ready);
endinterface
`default_nettype wire

FILE: design/sai_cell.sv
// one compare-and-shift cell of the sorted row
`default_nettype none
module sai_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sai_pkg::sai_ins_t  ins,
  input  wire sai_pkg::sai_link_t left,
  output sai_pkg::sai_link_t      link
);

  logic                              valid_r, valid_nxt;
  logic signed [sai_pkg::DATA_W-1:0] entry_r, entry_nxt;
  logic                              take;

  // first cell that takes marks the insertion slot, the rest shift right
  assign take = !valid_r || (entry_r >= ins.value);

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (ins.ins_en) begin
      valid_nxt = left.valid;
      if (left.take) begin
        entry_nxt = left.value;
      end else if (take) begin
        entry_nxt = ins.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign link.take  = take;
  assign link.valid = valid_r;
  assign link.value = entry_r;

endmodule
`default_nettype wire

FILE: design/sorted_array_insert_and_read_core.sv
// top level of the sorted insertion array
// Keeps up to sai_pkg::CAPACITY signed 32-bit values in ascending order in a row
// of compare-and-shift cells. On an insert every cell compares the new value with its
// own entry and either keeps it, takes the new value or takes its left neighbour's
// entry. A read selects the cell at the given position. Every item, insert or read,
// yields one result in the output register; a new item is accepted in the same
// cycle the previous result is transferred, so the block sustains one item per
// clock while the output is not stalled. Inserts into a full array are dropped with
// status full, reads at or beyond the occupancy return zero with status range.
`default_nettype none
`include "sorted_array_insert_and_read_core_macros.svh"
module sorted_array_insert_and_read_core (
  input  wire logic clk,
  input  wire logic rst_n,
  sai_in_if.sink    in_if,
  sai_out_if.source out_if
);

  sai_pkg::sai_link_t                link [sai_pkg::CAPACITY];
  sai_pkg::sai_link_t                head;
  sai_pkg::sai_ins_t                 ins;
  logic [sai_pkg::CAPACITY-1:0]      valid_vec;
  logic signed [sai_pkg::DATA_W-1:0] entries [sai_pkg::CAPACITY];

  logic                              accept, full, rd_ok;
  logic [sai_pkg::IDX_W-1:0]         rd_idx;
  logic [sai_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [sai_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  sai_pkg::sai_status_t              out_status_r, out_status_nxt;
  logic [sai_pkg::OCC_W-1:0]         out_occ_r, out_occ_nxt;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign full        = valid_vec[sai_pkg::CAPACITY-1];

  assign ins.ins_en = accept && (in_if.mode == sai_pkg::MODE_INSERT) && !full;
  assign ins.value  = in_if.value;

  // left end of the row: always valid, never shifts in
  assign head.take  = 1'b0;
  assign head.valid = 1'b1;
  assign head.value = in_if.value;

  for (genvar i = 0; i < sai_pkg::CAPACITY; i++) begin : g_cell
    sai_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ins  (ins),
      .left ((i == 0) ? head : link[(i == 0) ? 0 : i - 1]),
      .link (link[i])
    );
    assign valid_vec[i] = link[i].valid;
    assign entries[i]   = link[i].value;
  end

  assign rd_idx = in_if.position[sai_pkg::IDX_W-1:0];
  assign rd_ok  = (32'(in_if.position) < 32'(sai_pkg::CAPACITY)) && valid_vec[rd_idx];

  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = '0;
      out_status_nxt = sai_pkg::ST_OK;
      if (in_if.mode == sai_pkg::MODE_INSERT) begin
        if (full) begin
          out_status_nxt = sai_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end else if (rd_ok) begin
        out_value_nxt = entries[rd_idx];
      end else begin
        out_status_nxt = sai_pkg::ST_RANGE;
      end
      out_occ_nxt = sai_pkg::OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.read_value = out_value_r;
  assign out_if.status     = out_status_r;
  assign out_if.occupancy  = out_occ_r;

  // occupied cells always match the element count
  `SAI_ASSERT(a_count_matches_cells, $countones(valid_vec) == 32'(count_r),
    "cell valid bits disagree with element count")

  // a stored insert grows the array by exactly one
  `SAI_ASSERT_NEXT(a_insert_grows, ins.ins_en, count_r == $past(count_r) + 1'b1,
    "insert did not grow the element count")

  // a dropped insert is only reported when the array is full
  `SAI_ASSERT(a_full_drop, !(out_valid_r && out_status_r == sai_pkg::ST_FULL) ||
    (32'(out_occ_r) == 32'(sai_pkg::CAPACITY)), "full status with free room")

  // neighbouring occupied cells stay in ascending order
  for (genvar j = 1; j < sai_pkg::CAPACITY; j++) begin : g_order_chk
    `SAI_ASSERT(a_sorted, !valid_vec[j] || (entries[j-1] <= entries[j]),
      "stored entries out of order")
  end

endmodule
`default_nettype wire
